// ----- src/mas_pkg.sv -----
// Shared types and constants for the matrix add/subtract/multiply block.
`timescale 1ns / 1ps
package mas_pkg;
    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = IDX_W + 1;
    localparam int ELEM_BITS = 16;
    localparam int ACC_W     = 40;
    localparam int PROD_W    = 2 * ELEM_BITS;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 4;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd4;

    typedef struct packed {
        logic                        start_req;
        logic                        which_matrix;
        logic [2:0]                  row_index;
        logic [2:0]                  col_index;
        logic signed [ELEM_BITS-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]              out_row;
        logic [2:0]              out_col;
        logic signed [ACC_W-1:0] out_value;
        logic                    shape_error;
        logic                    last;
    } t_out_item;

    // Element write broadcast to every cell.
    typedef struct packed {
        logic                        valid;
        logic                        which;
        logic [IDX_W-1:0]            row;
        logic [IDX_W-1:0]            col;
        logic signed [ELEM_BITS-1:0] value;
    } t_load;

    // Run-wide controls, stable while a run is in flight.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [DIM_W-1:0] a_cols;
    } t_ctl;

    // Partial result travelling down the chain.
    typedef struct packed {
        logic                    valid;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last;
        logic signed [ACC_W-1:0] acc;
    } t_chain;
endpackage

// ----- src/mas_cell.sv -----
// One chain cell: holds column k of A, row k and column k of B, adds its term.
`timescale 1ns / 1ps
module mas_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [mas_pkg::IDX_W-1:0] i_cell_idx,
    input  mas_pkg::t_load        i_load,
    input  mas_pkg::t_ctl         i_ctl,
    input  mas_pkg::t_chain       i_chain,
    output mas_pkg::t_chain       o_chain
);
    logic signed [mas_pkg::ELEM_BITS-1:0] r_a_col  [mas_pkg::MAX_DIM];
    logic signed [mas_pkg::ELEM_BITS-1:0] r_b_row  [mas_pkg::MAX_DIM];
    logic signed [mas_pkg::ELEM_BITS-1:0] r_b_col  [mas_pkg::MAX_DIM];
    logic                                 r_valid;
    mas_pkg::t_chain                      r_chain;

    logic signed [mas_pkg::ELEM_BITS-1:0] a_el, b_el, bc_el;
    logic signed [mas_pkg::PROD_W-1:0]    prod;
    logic signed [mas_pkg::ELEM_BITS:0]   sum_el;
    logic signed [mas_pkg::ACC_W-1:0]     term;

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            if (!i_load.which && i_load.col == i_cell_idx) begin
                r_a_col[i_load.row] <= i_load.value;
            end
            if (i_load.which && i_load.row == i_cell_idx) begin
                r_b_row[i_load.col] <= i_load.value;
            end
            if (i_load.which && i_load.col == i_cell_idx) begin
                r_b_col[i_load.row] <= i_load.value;
            end
        end
    end

    always_comb begin
        a_el   = r_a_col[i_chain.row];
        b_el   = r_b_row[i_chain.col];
        bc_el  = r_b_col[i_chain.row];
        prod   = a_el * b_el;
        sum_el = (i_ctl.op == mas_pkg::OP_SUB)
               ? (mas_pkg::ELEM_BITS+1)'(a_el) - (mas_pkg::ELEM_BITS+1)'(bc_el)
               : (mas_pkg::ELEM_BITS+1)'(a_el) + (mas_pkg::ELEM_BITS+1)'(bc_el);
        term   = '0;
        case (i_ctl.op)
            mas_pkg::OP_MUL: begin
                if ({1'b0, i_cell_idx} < i_ctl.a_cols) begin
                    term = mas_pkg::ACC_W'(prod);
                end
            end
            mas_pkg::OP_ADD, mas_pkg::OP_SUB: begin
                if (i_chain.col == i_cell_idx) begin
                    term = mas_pkg::ACC_W'(sum_el) <<< 8;
                end
            end
            default: term = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_chain.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chain.valid <= i_chain.valid;
        r_chain.row   <= i_chain.row;
        r_chain.col   <= i_chain.col;
        r_chain.last  <= i_chain.last;
        r_chain.acc   <= i_chain.acc + term;
    end

    always_comb begin
        o_chain.valid = r_valid;
        o_chain.row   = r_chain.row;
        o_chain.col   = r_chain.col;
        o_chain.last  = r_chain.last;
        o_chain.acc   = r_chain.acc;
    end
endmodule

// ----- src/matrix_add_sub_multiply.sv -----
// Top level: configuration, run sequencer, chain of cells and result register.
`timescale 1ns / 1ps
// Dense matrix add / subtract / multiply on signed Q8.8 elements.
// Input channel: an item is taken at a clock edge with i_start high and
// o_busy low. A load item (start_req 0) writes one element of A or B
// and produces no result. A start item (start_req 1) runs the
// operation selected by the configuration registers.
// Configuration: write channel i_cfg_valid / o_cfg_ready (always ready),
// i_cfg_index selects a_rows, a_cols, b_rows, b_cols or operation.
// Write only while the block is idle.
// A run feeds one (row, col) pair per cycle into a chain of MAX_DIM cells;
// cell k holds column k of A and row/column k of B and adds its product
// (or its sum term for add/subtract) to the partial result passing by.
// Results leave the chain through the result register one per cycle,
// row-major, up to 64 results; the chain depth sets the latency, the
// one-pair-per-cycle issue sets the rate.
// A shape mismatch gives a single error result on the next cycle.
// Results show on o_item for one cycle with o_result high; the receiver
// cannot stall. Reset clears control state and restores the register
// defaults; the element stores hold garbage until written.
module matrix_add_sub_multiply (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  mas_pkg::t_in_item                   i_item,
    output logic                                o_result,
    output mas_pkg::t_out_item                  o_item,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mas_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mas_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    localparam logic [mas_pkg::DIM_W-1:0] DIM_MAX = mas_pkg::DIM_W'(mas_pkg::MAX_DIM);

    logic [mas_pkg::DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [mas_pkg::OP_W-1:0]  r_op;
    logic                      r_busy, r_issue;
    logic [mas_pkg::IDX_W-1:0] r_i, r_j;
    logic [mas_pkg::DIM_W-1:0] r_rows, r_cols;
    logic                      r_strobe;
    mas_pkg::t_out_item        r_out;

    logic                      accept, shape_ok, issue_last;
    mas_pkg::t_load            load;
    mas_pkg::t_ctl             ctl;
    mas_pkg::t_chain           chain [mas_pkg::MAX_DIM+1];

    assign o_cfg_ready = 1'b1;
    assign o_busy      = r_busy;
    assign accept      = i_start && !r_busy;

    // Hold configuration; unknown indexes drop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_rows <= mas_pkg::DIM_W'(1);
            r_a_cols <= mas_pkg::DIM_W'(1);
            r_b_rows <= mas_pkg::DIM_W'(1);
            r_b_cols <= mas_pkg::DIM_W'(1);
            r_op     <= mas_pkg::OP_MUL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mas_pkg::REG_A_ROWS:    r_a_rows <= i_cfg_data;
                mas_pkg::REG_A_COLS:    r_a_cols <= i_cfg_data;
                mas_pkg::REG_B_ROWS:    r_b_rows <= i_cfg_data;
                mas_pkg::REG_B_COLS:    r_b_cols <= i_cfg_data;
                mas_pkg::REG_OPERATION: r_op     <= i_cfg_data[mas_pkg::OP_W-1:0];
                default: ;
            endcase
        end
    end

    // Shape check: all dimensions in 1..MAX_DIM, then operation-specific fit.
    always_comb begin
        shape_ok = r_a_rows != '0 && r_a_rows <= DIM_MAX
                && r_a_cols != '0 && r_a_cols <= DIM_MAX
                && r_b_rows != '0 && r_b_rows <= DIM_MAX
                && r_b_cols != '0 && r_b_cols <= DIM_MAX;
        case (r_op)
            mas_pkg::OP_ADD, mas_pkg::OP_SUB:
                shape_ok = shape_ok && r_a_rows == r_b_rows && r_a_cols == r_b_cols;
            mas_pkg::OP_MUL:
                shape_ok = shape_ok && r_a_cols == r_b_rows;
            default:
                shape_ok = 1'b0;
        endcase
    end

    // Broadcast element writes to the cells.
    always_comb begin
        load.valid = accept && !i_item.start_req;
        load.which = i_item.which_matrix;
        load.row   = i_item.row_index;
        load.col   = i_item.col_index;
        load.value = i_item.element_value;
        ctl.op     = r_op;
        ctl.a_cols = r_a_cols;
    end

    assign issue_last = ({1'b0, r_i} == r_rows - mas_pkg::DIM_W'(1))
                     && ({1'b0, r_j} == r_cols - mas_pkg::DIM_W'(1));

    // Sequencer: walk the result matrix one element per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_issue <= 1'b0;
        end else begin
            if (accept && i_item.start_req && shape_ok) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
            end
            if (r_issue && issue_last) begin
                r_issue <= 1'b0;
            end
            if (chain[mas_pkg::MAX_DIM].valid && chain[mas_pkg::MAX_DIM].last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_item.start_req) begin
            r_i    <= '0;
            r_j    <= '0;
            r_rows <= r_a_rows;
            r_cols <= (r_op == mas_pkg::OP_MUL) ? r_b_cols : r_a_cols;
        end else if (r_issue) begin
            if ({1'b0, r_j} == r_cols - mas_pkg::DIM_W'(1)) begin
                r_j <= '0;
                r_i <= r_i + mas_pkg::IDX_W'(1);
            end else begin
                r_j <= r_j + mas_pkg::IDX_W'(1);
            end
        end
    end

    always_comb begin
        chain[0].valid = r_issue;
        chain[0].row   = r_i;
        chain[0].col   = r_j;
        chain[0].last  = issue_last;
        chain[0].acc   = '0;
    end

    for (genvar k = 0; k < mas_pkg::MAX_DIM; k++) begin : g_cell
        mas_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (mas_pkg::IDX_W'(k)),
            .i_load     (load),
            .i_ctl      (ctl),
            .i_chain    (chain[k]),
            .o_chain    (chain[k+1])
        );
    end

    // Result register: chain tail, or the single error item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= chain[mas_pkg::MAX_DIM].valid
                     || (accept && i_item.start_req && !shape_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain[mas_pkg::MAX_DIM].valid) begin
            r_out.out_row     <= chain[mas_pkg::MAX_DIM].row;
            r_out.out_col     <= chain[mas_pkg::MAX_DIM].col;
            r_out.out_value   <= chain[mas_pkg::MAX_DIM].acc;
            r_out.shape_error <= 1'b0;
            r_out.last        <= chain[mas_pkg::MAX_DIM].last;
        end else begin
            r_out.out_row     <= '0;
            r_out.out_col     <= '0;
            r_out.out_value   <= '0;
            r_out.shape_error <= 1'b1;
            r_out.last        <= 1'b1;
        end
    end

    assign o_result = r_strobe;
    assign o_item   = r_out;
endmodule
